[hw/rtl/som_best_matching_unit_macros.svh]
// Assertion shorthands shared by the search logic.
`ifndef SOM_BEST_MATCHING_UNIT_MACROS_SVH
`define SOM_BEST_MATCHING_UNIT_MACROS_SVH

// The condition must never hold outside reset.
`define BMU_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define BMU_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define BMU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bmu_pkg.sv]
`timescale 1ns / 1ps
package bmu_pkg;

   // Map and vector capacity. Powers of two, so that a node's weight
   // address is the concatenation of its coordinates and element index.
   localparam int MAX_MAP_X   = 16;
   localparam int MAX_MAP_Y   = 16;
   localparam int MAX_VEC_LEN = 16;

   localparam int X_AW   = $clog2(MAX_MAP_X);
   localparam int Y_AW   = $clog2(MAX_MAP_Y);
   localparam int E_AW   = $clog2(MAX_VEC_LEN);
   localparam int MEM_AW = X_AW + Y_AW + E_AW;

   // Fixed widths of the word fields.
   localparam int IDX_W     = 4;
   localparam int VALUE_W   = 16;
   localparam int DIFF_W    = VALUE_W + 1;
   localparam int SQ_W      = 2 * VALUE_W;
   localparam int DIST_W    = 36;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 2;

   // Command codes.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT
   } state_type;

   // One accepted request word.
   typedef struct packed {
      logic                      cmd;
      logic [IDX_W-1:0]          node_x;
      logic [IDX_W-1:0]          node_y;
      logic [IDX_W-1:0]          element;
      logic signed [VALUE_W-1:0] value;
   } item_type;

   // Effective configuration, already clamped to its legal range.
   typedef struct packed {
      logic [CFG_W-1:0] map_w;
      logic [CFG_W-1:0] map_h;
      logic [CFG_W-1:0] vec_len;
   } cfg_type;

   // One weight element read of the scan, tagged with its node.
   typedef struct packed {
      logic            valid;
      logic            first_node;
      logic            last_node;
      logic            last_elem;
      logic [X_AW-1:0] x;
      logic [Y_AW-1:0] y;
      logic [E_AW-1:0] e;
   } scan_type;

   // A finished node distance leaving the datapath.
   typedef struct packed {
      logic            valid;
      logic            first_node;
      logic            last_node;
      logic [X_AW-1:0] x;
      logic [Y_AW-1:0] y;
   } node_type;

   // A register value of zero counts as one, and a value above the limit
   // counts as the limit.
   function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                  input int unsigned maxv);
      if (v == '0) begin
         return CFG_W'(1);
      end
      if (32'(v) > maxv) begin
         return CFG_W'(maxv);
      end
      return v;
   endfunction

endpackage

[hw/rtl/bmu_if.sv]
`timescale 1ns / 1ps
// Request channel: weight loads and query elements.
interface bmu_req_if import bmu_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [IDX_W-1:0]          node_x;
   logic [IDX_W-1:0]          node_y;
   logic [IDX_W-1:0]          element;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output node_x, output node_y,
                   output element, output value, input ready);
   modport sink   (input valid, input cmd, input node_x, input node_y,
                   input element, input value, output ready);
endinterface

// Response channel: one winner per search.
interface bmu_rsp_if import bmu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  winner_x;
   logic [IDX_W-1:0]  winner_y;
   logic [DIST_W-1:0] best_distance;

   modport source (output valid, output winner_x, output winner_y,
                   output best_distance, input ready);
   modport sink   (input valid, input winner_x, input winner_y,
                   input best_distance, output ready);
endinterface

[hw/rtl/bmu_csr.sv]
`timescale 1ns / 1ps
module bmu_csr import bmu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_VEC_LEN    = CSR_IDX_W'(2);

   logic [CFG_W-1:0] map_w_ff;
   logic [CFG_W-1:0] map_h_ff;
   logic [CFG_W-1:0] vec_len_ff;

   // Register writes; an unknown index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_w_ff   <= CFG_W'(16);
         map_h_ff   <= CFG_W'(16);
         vec_len_ff <= CFG_W'(16);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAP_WIDTH:  map_w_ff   <= csr_wdata;
            REG_MAP_HEIGHT: map_h_ff   <= csr_wdata;
            REG_VEC_LEN:    vec_len_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // Effective values seen by the scan.
   always_comb begin
      cfg.map_w   = clamp_cfg(map_w_ff, MAX_MAP_X);
      cfg.map_h   = clamp_cfg(map_h_ff, MAX_MAP_Y);
      cfg.vec_len = clamp_cfg(vec_len_ff, MAX_VEC_LEN);
   end

endmodule

[hw/rtl/bmu_ctrl.sv]
`timescale 1ns / 1ps
module bmu_ctrl import bmu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_fire,
   input  item_type item,
   input  logic     committed,
   output logic     req_ready,
   output scan_type scan
);

   state_type       state_ff, state_in;
   logic [X_AW-1:0] x_ff, x_in;
   logic [Y_AW-1:0] y_ff, y_in;
   logic [E_AW-1:0] e_ff, e_in;
   logic            start;
   logic            x_end, y_end, e_end;

   // A query word at the last element position starts a search.
   assign start = req_fire && (item.cmd == CMD_QUERY) &&
                  (32'(item.element) < MAX_VEC_LEN) &&
                  (CFG_W'(item.element) == cfg.vec_len - CFG_W'(1));

   assign x_end = (CFG_W'(x_ff) == cfg.map_w - CFG_W'(1));
   assign y_end = (CFG_W'(y_ff) == cfg.map_h - CFG_W'(1));
   assign e_end = (CFG_W'(e_ff) == cfg.vec_len - CFG_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_SCAN;
         ST_SCAN: if (x_end && y_end && e_end) state_in = ST_WAIT;
         ST_WAIT: if (committed) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Scan counters: element innermost, then y, then x.
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      e_in = e_ff;
      if (state_ff != ST_SCAN) begin
         x_in = '0;
         y_in = '0;
         e_in = '0;
      end else if (!e_end) begin
         e_in = e_ff + E_AW'(1);
      end else begin
         e_in = '0;
         if (!y_end) begin
            y_in = y_ff + Y_AW'(1);
         end else begin
            y_in = '0;
            x_in = x_ff + X_AW'(1);
         end
      end
   end

   // Outputs. No word is taken while a search owns the weight memory.
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      scan.valid      = (state_ff == ST_SCAN);
      scan.first_node = (x_ff == '0) && (y_ff == '0);
      scan.last_node  = x_end && y_end;
      scan.last_elem  = e_end;
      scan.x          = x_ff;
      scan.y          = y_ff;
      scan.e          = e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         x_ff     <= '0;
         y_ff     <= '0;
         e_ff     <= '0;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         e_ff     <= e_in;
      end
   end

`include "som_best_matching_unit_macros.svh"

   `BMU_ASSERT_NEVER(a_no_accept_in_scan, req_ready && (state_ff == ST_SCAN), "word accepted during scan")
   `BMU_ASSERT_IMPLY(a_elem_in_range, scan.valid, (CFG_W'(scan.e) < cfg.vec_len), "element index past vector length")
   `BMU_ASSERT_NEXT(a_scan_ends, scan.valid && scan.last_node && scan.last_elem, state_ff == ST_WAIT, "scan did not end after last node")

endmodule

[hw/rtl/bmu_dist.sv]
`timescale 1ns / 1ps
module bmu_dist import bmu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  item_type          item,
   input  scan_type          scan,
   output node_type          node,
   output logic [DIST_W-1:0] node_dist
);

   logic signed [VALUE_W-1:0] weight_mem [2**MEM_AW];
   logic signed [VALUE_W-1:0] query_ff [MAX_VEC_LEN];

   logic                      load_we;
   logic                      query_we;
   logic [MEM_AW-1:0]         wr_addr;
   logic [MEM_AW-1:0]         rd_addr;

   logic signed [VALUE_W-1:0] w_rd_ff;
   logic signed [VALUE_W-1:0] q_rd_ff;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [2*DIFF_W-1:0] prod;
   logic [SQ_W-1:0]           sq_ff;
   logic [DIST_W:0]           sum;
   logic [DIST_W-1:0]         acc_ff, acc_in;
   scan_type                  s1_ff, s2_ff, s3_ff;
   node_type                  node_ff, node_in;

   // Weight loads outside the map are dropped.
   assign load_we  = req_fire && (item.cmd == CMD_LOAD) &&
                     (32'(item.node_x) < MAX_MAP_X) &&
                     (32'(item.node_y) < MAX_MAP_Y) &&
                     (32'(item.element) < MAX_VEC_LEN);
   assign query_we = req_fire && (item.cmd == CMD_QUERY) &&
                     (32'(item.element) < MAX_VEC_LEN);
   assign wr_addr  = {item.node_x[X_AW-1:0], item.node_y[Y_AW-1:0],
                      item.element[E_AW-1:0]};
   assign rd_addr  = {scan.x, scan.y, scan.e};

   // Weight memory. Writes and scan reads never share a cycle, since the
   // controller takes no word while a search runs.
   always_ff @(posedge clock) begin
      if (load_we) begin
         weight_mem[wr_addr] <= item.value;
      end
      w_rd_ff <= weight_mem[rd_addr];
   end

   // Query vector buffer, read in step with the weight memory.
   always_ff @(posedge clock) begin
      if (query_we) begin
         query_ff[item.element[E_AW-1:0]] <= item.value;
      end
      q_rd_ff <= query_ff[scan.e];
   end

   // Difference, square and running sum, one register apart.
   assign diff_in = DIFF_W'(w_rd_ff) - DIFF_W'(q_rd_ff);
   assign prod    = diff_ff * diff_ff;
   assign sum     = (s3_ff.e == '0 ? (DIST_W + 1)'(0) : (DIST_W + 1)'(acc_ff)) +
                    (DIST_W + 1)'(sq_ff);
   // Saturate a sum that would pass the distance width.
   assign acc_in  = sum[DIST_W] ? '1 : sum[DIST_W-1:0];

   always_comb begin
      node_in.valid      = s3_ff.valid && s3_ff.last_elem;
      node_in.first_node = s3_ff.first_node;
      node_in.last_node  = s3_ff.last_node;
      node_in.x          = s3_ff.x;
      node_in.y          = s3_ff.y;
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= prod[SQ_W-1:0];
      if (s3_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // Stage tags follow the data down the pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         s3_ff   <= '0;
         node_ff <= '0;
      end else begin
         s1_ff   <= scan;
         s2_ff   <= s1_ff;
         s3_ff   <= s2_ff;
         node_ff <= node_in;
      end
   end

   assign node      = node_ff;
   assign node_dist = acc_ff;

endmodule

[hw/rtl/bmu_select.sv]
`timescale 1ns / 1ps
module bmu_select import bmu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  node_type          node,
   input  logic [DIST_W-1:0] node_dist,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  winner_x,
   output logic [IDX_W-1:0]  winner_y,
   output logic [DIST_W-1:0] best_distance,
   output logic              committed
);

   logic [DIST_W-1:0] best_dist_ff;
   logic [X_AW-1:0]   best_x_ff;
   logic [Y_AW-1:0]   best_y_ff;
   logic              pending_ff, pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_x_ff;
   logic [IDX_W-1:0]  rsp_y_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              take;

   // The first node seeds the minimum; later nodes win only when
   // strictly closer, so ties keep the earliest node.
   assign take = node.valid && (node.first_node || (node_dist < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_dist_ff <= node_dist;
         best_x_ff    <= node.x;
         best_y_ff    <= node.y;
      end
   end

   // The winner waits here until the response register is free.
   assign committed    = pending_ff && (!rsp_valid_ff || rsp_ready);
   assign pending_in   = (node.valid && node.last_node) ? 1'b1 :
                         (committed ? 1'b0 : pending_ff);
   assign rsp_valid_in = committed ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (committed) begin
         rsp_x_ff    <= IDX_W'(best_x_ff);
         rsp_y_ff    <= IDX_W'(best_y_ff);
         rsp_dist_ff <= best_dist_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign winner_x      = rsp_x_ff;
   assign winner_y      = rsp_y_ff;
   assign best_distance = rsp_dist_ff;

`include "som_best_matching_unit_macros.svh"

   `BMU_ASSERT_NEVER(a_no_node_while_pending, node.valid && pending_ff, "node result while winner still pending")
   `BMU_ASSERT_NEXT(a_commit_shows, committed, rsp_valid_ff, "committed winner not shown")
   `BMU_ASSERT_NEXT(a_commit_clears, committed, !pending_ff, "winner still pending after commit")

endmodule

[hw/rtl/som_best_matching_unit.sv]
`timescale 1ns / 1ps
// A search word starts a scan that reads one weight element per cycle from the weight
// memory, which has a write port and a separate read port. Loads and other query words
// are taken back to back while the block is idle. New words are taken again as soon as
// the winner is shown in the response register.
// Reset (synchronous, active high) clears control state and sets all three registers
// to 16; weight memory and query buffer keep their contents.
module som_best_matching_unit import bmu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bmu_req_if.sink              req_ch,
   bmu_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type           cfg;
   item_type          item;
   scan_type          scan;
   node_type          node;
   logic [DIST_W-1:0] node_dist;
   logic              req_ready;
   logic              req_fire;
   logic              committed;

   assign item.cmd     = req_ch.cmd;
   assign item.node_x  = req_ch.node_x;
   assign item.node_y  = req_ch.node_y;
   assign item.element = req_ch.element;
   assign item.value   = req_ch.value;

   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;

   bmu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_fire  (req_fire),
      .item      (item),
      .committed (committed),
      .req_ready (req_ready),
      .scan      (scan)
   );

   bmu_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .item      (item),
      .scan      (scan),
      .node      (node),
      .node_dist (node_dist)
   );

   bmu_select u_select (
      .clock         (clock),
      .reset         (reset),
      .node          (node),
      .node_dist     (node_dist),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .winner_x      (rsp_ch.winner_x),
      .winner_y      (rsp_ch.winner_y),
      .best_distance (rsp_ch.best_distance),
      .committed     (committed)
   );

endmodule
